[hdl/dds_pkg.sv]
package dds_pkg;

	// table and phase geometry (table depth is a power of two)
	localparam int TABLE_DEPTH = 256;
	localparam int PHASE_BITS  = 32;
	localparam int SAMPLE_BITS = 12;
	localparam int IDX_BITS    = $clog2(TABLE_DEPTH);

	// field widths
	localparam int STEP_BITS  = 32;
	localparam int TICK_BITS  = 32;
	localparam int CTRL_BITS  = 4;
	localparam int LEVEL_BITS = 12;
	localparam int CMD_BITS   = 16;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	// result queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// register reset values
	localparam logic [LEVEL_BITS-1:0] LEVEL_RST = LEVEL_BITS'(2048);
	localparam logic [TICK_BITS-1:0]  TICKS_RST = TICK_BITS'(1);
	localparam logic [CTRL_BITS-1:0]  CTRL_RST  = CTRL_BITS'(3);

	// register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_PHASE_STEP  = 3'd0,
		CFG_WAVE_MODE   = 3'd1,
		CFG_HIGH_LEVEL  = 3'd2,
		CFG_LOW_LEVEL   = 3'd3,
		CFG_HIGH_TICKS  = 3'd4,
		CFG_LOW_TICKS   = 3'd5,
		CFG_DAC_CONTROL = 3'd6
	} cfg_idx_t;

	// operation codes
	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	// wave modes
	typedef enum logic {
		MODE_TABLE  = 1'b0,
		MODE_SQUARE = 1'b1
	} mode_t;

	// one result word
	typedef struct packed {
		logic [CMD_BITS-1:0] dac_command;
		logic                level_changed;
	} rsp_t;

endpackage

[hdl/dds_if.sv]
// request channel: ticks and table writes
interface dds_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [7:0]  table_index;
	logic [11:0] table_value;

	modport source (output valid, operation, table_index, table_value, input ready);
	modport sink   (input valid, operation, table_index, table_value, output ready);
endinterface

// response channel: dac command words
interface dds_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] dac_command;
	logic        level_changed;

	modport source (output valid, dac_command, level_changed, input ready);
	modport sink   (input valid, dac_command, level_changed, output ready);
endinterface

// configuration write channel
interface dds_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[hdl/dds_waveform_square_generator.sv]
// channel | dir | word                                         | accepted when
// req     | in  | operation, table_index, table_value          | req.valid && req.ready
// rsp     | out | dac_command, level_changed                   | rsp.valid && rsp.ready
// cfg     | in  | index, data                                  | cfg.valid && cfg.ready
//
// one request word per cycle while req.ready is high; a tick gives its response once it has
// passed the table ram read and then the result queue, a table write gives none
// the rate is set by the table's single read port and the phase add, one per cycle
// arst_n clears control state and loads register defaults; the table is not cleared
// a four-word result queue parts the sides; req.ready drops only when it cannot
// take one more word besides the one in flight
module dds_waveform_square_generator (
	input logic clk,
	input logic arst_n,
	dds_req_if.sink   req,
	dds_rsp_if.source rsp,
	dds_cfg_if.sink   cfg
);

	// configuration registers
	logic [dds_pkg::STEP_BITS-1:0]  phase_step_q;
	logic                           wave_mode_q;
	logic [dds_pkg::LEVEL_BITS-1:0] high_level_q;
	logic [dds_pkg::LEVEL_BITS-1:0] low_level_q;
	logic [dds_pkg::TICK_BITS-1:0]  high_ticks_q;
	logic [dds_pkg::TICK_BITS-1:0]  low_ticks_q;
	logic [dds_pkg::CTRL_BITS-1:0]  dac_control_q;

	// generator state
	logic [dds_pkg::PHASE_BITS-1:0] phase_q;
	logic                           sq_high_q;
	logic [dds_pkg::TICK_BITS-1:0]  sq_count_q;

	// stage one
	logic                            valid_s1;
	logic                            square_s1;
	logic [dds_pkg::SAMPLE_BITS-1:0] code_s1;
	logic                            changed_s1;

	// result queue
	dds_pkg::rsp_t                fifo_q [dds_pkg::FIFO_DEPTH];
	logic [dds_pkg::FIFO_AW-1:0]  wr_ptr_q;
	logic [dds_pkg::FIFO_AW-1:0]  rd_ptr_q;
	logic [dds_pkg::FIFO_CW-1:0]  cnt_q;

	logic                            req_acc;
	logic                            tick_acc;
	logic                            tbl_tick;
	logic                            sq_tick;
	logic                            tbl_we;
	logic [dds_pkg::PHASE_BITS-1:0]  phase_next;
	logic [dds_pkg::IDX_BITS-1:0]    rd_idx;
	logic [dds_pkg::SAMPLE_BITS-1:0] ram_rdata;
	logic [dds_pkg::TICK_BITS-1:0]   limit;
	logic                            toggle;
	logic                            sq_high_next;
	logic [dds_pkg::SAMPLE_BITS-1:0] sq_code;
	logic [dds_pkg::SAMPLE_BITS-1:0] push_code;
	dds_pkg::rsp_t                   push_word;
	logic                            pop;

	// handshakes
	assign cfg.ready = 1'b1;
	assign req.ready = ((dds_pkg::FIFO_CW + 1)'(cnt_q) + (dds_pkg::FIFO_CW + 1)'(valid_s1))
		< (dds_pkg::FIFO_CW + 1)'(dds_pkg::FIFO_DEPTH);
	assign req_acc  = req.valid && req.ready;
	assign tick_acc = req_acc && (req.operation == dds_pkg::OP_TICK);
	assign tbl_tick = tick_acc && (wave_mode_q == dds_pkg::MODE_TABLE);
	assign sq_tick  = tick_acc && (wave_mode_q == dds_pkg::MODE_SQUARE);
	assign tbl_we   = req_acc && (req.operation == dds_pkg::OP_WRITE)
		&& (32'(req.table_index) < 32'(dds_pkg::TABLE_DEPTH));

	// phase add and table index from the top phase bits
	assign phase_next = phase_q + dds_pkg::PHASE_BITS'(phase_step_q);
	assign rd_idx     = phase_next[dds_pkg::PHASE_BITS-1 -: dds_pkg::IDX_BITS];

	// square half-period check, a zero count acts as one
	always_comb begin
		limit = sq_high_q ? high_ticks_q : low_ticks_q;
		if (limit == '0) begin
			limit = dds_pkg::TICK_BITS'(1);
		end
		toggle       = (sq_count_q >= limit);
		sq_high_next = sq_high_q ^ toggle;
		sq_code      = dds_pkg::SAMPLE_BITS'(sq_high_next ? high_level_q : low_level_q);
	end

	// sample table
	dds_ram #(
		.WIDTH (dds_pkg::SAMPLE_BITS),
		.DEPTH (dds_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (dds_pkg::IDX_BITS'(req.table_index)),
		.wdata (dds_pkg::SAMPLE_BITS'(req.table_value)),
		.re    (tbl_tick),
		.raddr (rd_idx),
		.rdata (ram_rdata)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q  <= '0;
			wave_mode_q   <= dds_pkg::MODE_TABLE;
			high_level_q  <= dds_pkg::LEVEL_RST;
			low_level_q   <= dds_pkg::LEVEL_RST;
			high_ticks_q  <= dds_pkg::TICKS_RST;
			low_ticks_q   <= dds_pkg::TICKS_RST;
			dac_control_q <= dds_pkg::CTRL_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (dds_pkg::cfg_idx_t'(cfg.index))
				dds_pkg::CFG_PHASE_STEP:  phase_step_q  <= dds_pkg::STEP_BITS'(cfg.data);
				dds_pkg::CFG_WAVE_MODE:   wave_mode_q   <= cfg.data[0];
				dds_pkg::CFG_HIGH_LEVEL:  high_level_q  <= dds_pkg::LEVEL_BITS'(cfg.data);
				dds_pkg::CFG_LOW_LEVEL:   low_level_q   <= dds_pkg::LEVEL_BITS'(cfg.data);
				dds_pkg::CFG_HIGH_TICKS:  high_ticks_q  <= dds_pkg::TICK_BITS'(cfg.data);
				dds_pkg::CFG_LOW_TICKS:   low_ticks_q   <= dds_pkg::TICK_BITS'(cfg.data);
				dds_pkg::CFG_DAC_CONTROL: dac_control_q <= dds_pkg::CTRL_BITS'(cfg.data);
				default: ;
			endcase
		end
	end

	// phase and square state update at tick accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			sq_high_q  <= 1'b0;
			sq_count_q <= '0;
		end else begin
			if (tbl_tick) begin
				phase_q <= phase_next;
			end
			if (sq_tick) begin
				sq_high_q  <= sq_high_next;
				sq_count_q <= toggle ? dds_pkg::TICK_BITS'(1) : sq_count_q + 1'b1;
			end
		end
	end

	// stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= tick_acc;
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			square_s1  <= sq_tick;
			code_s1    <= sq_code;
			changed_s1 <= sq_tick && toggle;
		end
	end

	// result word built from the table read or the square level
	assign push_code = square_s1 ? code_s1 : ram_rdata;
	assign push_word.dac_command   = dds_pkg::CMD_BITS'({dac_control_q, push_code});
	assign push_word.level_changed = changed_s1;

	// result queue
	assign pop               = rsp.valid && rsp.ready;
	assign rsp.valid         = (cnt_q != '0);
	assign rsp.dac_command   = fifo_q[rd_ptr_q].dac_command;
	assign rsp.level_changed = fifo_q[rd_ptr_q].level_changed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (valid_s1) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + dds_pkg::FIFO_CW'(valid_s1) - dds_pkg::FIFO_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			fifo_q[wr_ptr_q] <= push_word;
		end
	end

	// queue never overflows
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (cnt_q != dds_pkg::FIFO_CW'(dds_pkg::FIFO_DEPTH)))
		else $error("result queue overflow");

	// a table write causes no result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && (req.operation == dds_pkg::OP_WRITE)) |=> !valid_s1)
		else $error("table write produced a result");

	// every tick reaches stage one
	a_tick_flows: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> valid_s1)
		else $error("accepted tick lost");

	// table ticks never flag a level change
	a_table_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !square_s1) |-> !changed_s1)
		else $error("level change on a table tick");

	// a square tick leaves a nonzero half-period count
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		sq_tick |=> (sq_count_q != '0))
		else $error("square count wrapped");

endmodule

[hdl/dds_ram.sv]
module dds_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
